>>> src/m68k_alu_and_condition_test_core_assert.svh
// assertion macros for the m68k alu core
// no dependencies; included by the top level
`ifndef M68K_ALU_AND_CONDITION_TEST_CORE_ASSERT_SVH
`define M68K_ALU_AND_CONDITION_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define M68K_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m68k core assertion failed");

// next-cycle implication
`define M68K_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m68k core assertion failed");

`endif

>>> src/m68k_pkg.sv
// shared types and codes for the m68k alu core
// no dependencies; used by the front, queue, back and top level files
`timescale 1ns / 1ps

package m68k_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] OP_MOVE = 5'd0;
  localparam logic [4:0] OP_AND  = 5'd1;
  localparam logic [4:0] OP_OR   = 5'd2;
  localparam logic [4:0] OP_EOR  = 5'd3;
  localparam logic [4:0] OP_ADD  = 5'd4;
  localparam logic [4:0] OP_SUB  = 5'd5;
  localparam logic [4:0] OP_CMP  = 5'd6;
  localparam logic [4:0] OP_ADDA = 5'd7;
  localparam logic [4:0] OP_SUBA = 5'd8;
  localparam logic [4:0] OP_LSL  = 5'd9;
  localparam logic [4:0] OP_LSR  = 5'd10;
  localparam logic [4:0] OP_ASR  = 5'd11;
  localparam logic [4:0] OP_ROL  = 5'd12;
  localparam logic [4:0] OP_ROR  = 5'd13;
  localparam logic [4:0] OP_BTST = 5'd14;
  localparam logic [4:0] OP_BCHG = 5'd15;
  localparam logic [4:0] OP_BCLR = 5'd16;
  localparam logic [4:0] OP_BSET = 5'd17;
  localparam logic [4:0] OP_COND = 5'd18;
  localparam logic [4:0] OP_NOP  = 5'd19;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;
  localparam logic [1:0] SZ_RSVD = 2'd3;

  localparam logic [3:0] CC_T  = 4'd0;
  localparam logic [3:0] CC_F  = 4'd1;
  localparam logic [3:0] CC_HI = 4'd2;
  localparam logic [3:0] CC_LS = 4'd3;
  localparam logic [3:0] CC_CC = 4'd4;
  localparam logic [3:0] CC_CS = 4'd5;
  localparam logic [3:0] CC_NE = 4'd6;
  localparam logic [3:0] CC_EQ = 4'd7;
  localparam logic [3:0] CC_VC = 4'd8;
  localparam logic [3:0] CC_VS = 4'd9;
  localparam logic [3:0] CC_PL = 4'd10;
  localparam logic [3:0] CC_MI = 4'd11;
  localparam logic [3:0] CC_GE = 4'd12;
  localparam logic [3:0] CC_LT = 4'd13;
  localparam logic [3:0] CC_GT = 4'd14;
  localparam logic [3:0] CC_LE = 4'd15;

  typedef struct packed {
    logic [4:0]  op;
    logic [1:0]  size;
    logic [31:0] source_value;
    logic [31:0] dest_value;
    logic [3:0]  cond_code;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

endpackage

>>> src/m68k_if.sv
// request and result channel interfaces of the m68k alu core
// no dependencies
`timescale 1ns / 1ps

interface m68k_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [1:0]  size;
  logic [31:0] source_value;
  logic [31:0] dest_value;
  logic [3:0]  cond_code;

  modport source (output valid, mode, size, source_value, dest_value, cond_code,
                  input ready);
  modport sink (input valid, mode, size, source_value, dest_value, cond_code,
                output ready);
endinterface

interface m68k_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        flag_n;
  logic        flag_z;
  logic        flag_v;
  logic        flag_c;
  logic        cond_true;

  modport source (output valid, result_value, flag_n, flag_z, flag_v, flag_c, cond_true,
                  input ready);
  modport sink (input valid, result_value, flag_n, flag_z, flag_v, flag_c, cond_true,
                output ready);
endinterface

>>> src/m68k_front.sv
// front stage: accepts request items, normalizes size and operation
// depends on m68k_pkg and m68k_if
`timescale 1ns / 1ps

module m68k_front (
  input  logic                clk,
  input  logic                rst,
  m68k_req_if.sink            request,
  input  m68k_pkg::q_stat_t   q_stat,
  output m68k_pkg::entry_t    front
);

  logic              f_valid;
  m68k_pkg::item_t   f_item;
  m68k_pkg::item_t   dec;

  assign request.ready = !f_valid || !q_stat.full;
  assign front.valid   = f_valid;
  assign front.item    = f_item;

  always_comb begin
    dec.op           = (request.mode > m68k_pkg::OP_COND) ? m68k_pkg::OP_NOP : request.mode;
    dec.size         = (request.size == m68k_pkg::SZ_RSVD) ? m68k_pkg::SZ_LONG : request.size;
    dec.source_value = request.source_value;
    dec.dest_value   = request.dest_value;
    dec.cond_code    = request.cond_code;
    // address ops have no byte form
    if ((dec.op == m68k_pkg::OP_ADDA || dec.op == m68k_pkg::OP_SUBA) &&
        dec.size == m68k_pkg::SZ_BYTE) begin
      dec.size = m68k_pkg::SZ_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (request.ready) begin
      f_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      f_item <= dec;
    end
  end

endmodule

>>> src/m68k_queue.sv
// short item queue between front and back stages
// depends on m68k_pkg
`timescale 1ns / 1ps

module m68k_queue #(
  parameter int DEPTH = m68k_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  m68k_pkg::entry_t   front,
  input  logic               pop,
  output m68k_pkg::entry_t   head,
  output m68k_pkg::q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  m68k_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop_ok;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign push       = front.valid && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign head.valid = !stat.empty;
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop_ok) begin
        count <= count + 1'b1;
      end else if (!push && pop_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= front.item;
    end
  end

endmodule

>>> src/m68k_back.sv
// back stage: executes the alu operation, keeps the flags, registers the result
// depends on m68k_pkg and m68k_if
`timescale 1ns / 1ps

module m68k_back (
  input  logic              clk,
  input  logic              rst,
  input  m68k_pkg::entry_t  head,
  output logic              pop,
  m68k_rsp_if.source        result
);

  m68k_pkg::flags_t flags;
  m68k_pkg::flags_t fl;
  logic             out_valid;

  logic [4:0]  op;
  logic [1:0]  sz;
  logic [31:0] src;
  logic [31:0] dst;
  logic [3:0]  cc;
  logic [31:0] m;
  logic [31:0] d;
  logic [31:0] s;
  logic [4:0]  cnt;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [63:0] shl;
  logic [32:0] shr;
  logic [31:0] sx;
  logic [32:0] sar;
  logic [15:0] rol8;
  logic [31:0] rol16;
  logic [63:0] rol32;
  logic [15:0] ror8;
  logic [31:0] ror16;
  logic [63:0] ror32;
  logic [31:0] rot;
  logic [31:0] am;
  logic [4:0]  bn;
  logic [31:0] bitm;
  logic [31:0] r;
  logic [31:0] res;
  logic        ct;
  logic        sc;

  function automatic logic top_bit(input logic [31:0] x, input logic [1:0] size);
    logic b;
    case (size)
      m68k_pkg::SZ_BYTE: b = x[7];
      m68k_pkg::SZ_WORD: b = x[15];
      default:           b = x[31];
    endcase
    return b;
  endfunction

  assign pop = head.valid && (!out_valid || result.ready);

  assign op  = head.item.op;
  assign sz  = head.item.size;
  assign src = head.item.source_value;
  assign dst = head.item.dest_value;
  assign cc  = head.item.cond_code;
  assign cnt = src[4:0];

  always_comb begin
    case (sz)
      m68k_pkg::SZ_BYTE: m = 32'h0000_00FF;
      m68k_pkg::SZ_WORD: m = 32'h0000_FFFF;
      default:           m = 32'hFFFF_FFFF;
    endcase
  end

  assign d     = dst & m;
  assign s     = src & m;
  assign sum   = {1'b0, d} + {1'b0, s};
  assign diff  = {1'b0, d} - {1'b0, s};
  assign shl   = {32'd0, d} << cnt;
  assign shr   = {d, 1'b0} >> cnt;
  assign sx    = top_bit(d, sz) ? (d | ~m) : d;
  assign sar   = 33'($signed({sx, 1'b0}) >>> cnt);
  assign rol8  = {d[7:0], d[7:0]} << cnt[2:0];
  assign rol16 = {d[15:0], d[15:0]} << cnt[3:0];
  assign rol32 = {d, d} << cnt;
  assign ror8  = {d[7:0], d[7:0]} >> cnt[2:0];
  assign ror16 = {d[15:0], d[15:0]} >> cnt[3:0];
  assign ror32 = {d, d} >> cnt;
  assign am    = (sz == m68k_pkg::SZ_WORD) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
  assign bn    = (sz == m68k_pkg::SZ_BYTE) ? {2'b00, src[2:0]} : src[4:0];
  assign bitm  = 32'd1 << bn;

  always_comb begin
    if (op == m68k_pkg::OP_ROL) begin
      case (sz)
        m68k_pkg::SZ_BYTE: rot = {24'd0, rol8[15:8]};
        m68k_pkg::SZ_WORD: rot = {16'd0, rol16[31:16]};
        default:           rot = rol32[63:32];
      endcase
    end else begin
      case (sz)
        m68k_pkg::SZ_BYTE: rot = {24'd0, ror8[7:0]};
        m68k_pkg::SZ_WORD: rot = {16'd0, ror16[15:0]};
        default:           rot = ror32[31:0];
      endcase
    end
  end

  always_comb begin
    case (sz)
      m68k_pkg::SZ_BYTE: sc = shl[8];
      m68k_pkg::SZ_WORD: sc = shl[16];
      default:           sc = shl[32];
    endcase
  end

  always_comb begin
    res = dst;
    fl  = flags;
    ct  = 1'b0;
    r   = '0;
    case (op)
      m68k_pkg::OP_MOVE: begin
        res = (dst & ~m) | s;
      end
      m68k_pkg::OP_AND, m68k_pkg::OP_OR, m68k_pkg::OP_EOR: begin
        if (op == m68k_pkg::OP_AND) begin
          r = d & s;
        end else if (op == m68k_pkg::OP_OR) begin
          r = d | s;
        end else begin
          r = d ^ s;
        end
        res  = (dst & ~m) | r;
        fl.n = top_bit(r, sz);
        fl.z = (r == '0);
        fl.v = 1'b0;
        fl.c = 1'b0;
      end
      m68k_pkg::OP_ADD: begin
        r    = sum[31:0] & m;
        res  = (dst & ~m) | r;
        fl.n = top_bit(r, sz);
        fl.z = (r == '0);
        case (sz)
          m68k_pkg::SZ_BYTE: fl.c = sum[8];
          m68k_pkg::SZ_WORD: fl.c = sum[16];
          default:           fl.c = sum[32];
        endcase
      end
      m68k_pkg::OP_SUB, m68k_pkg::OP_CMP: begin
        r = diff[31:0] & m;
        if (op == m68k_pkg::OP_SUB) begin
          res = (dst & ~m) | r;
        end
        fl.n = top_bit(r, sz);
        fl.z = (r == '0);
        fl.c = diff[32];
      end
      m68k_pkg::OP_ADDA, m68k_pkg::OP_SUBA: begin
        r   = (op == m68k_pkg::OP_ADDA) ? (dst + src) : (dst - src);
        res = (dst & ~am) | (r & am);
      end
      m68k_pkg::OP_LSL, m68k_pkg::OP_LSR, m68k_pkg::OP_ASR: begin
        if (op == m68k_pkg::OP_LSL) begin
          r    = shl[31:0] & m;
          fl.c = sc;
        end else if (op == m68k_pkg::OP_LSR) begin
          r    = shr[32:1] & m;
          fl.c = shr[0];
        end else begin
          r    = sar[32:1] & m;
          fl.c = sar[0];
        end
        res  = (dst & ~m) | r;
        fl.n = top_bit(r, sz);
        fl.z = (r == '0);
        fl.v = 1'b0;
      end
      m68k_pkg::OP_ROL, m68k_pkg::OP_ROR: begin
        r    = rot;
        res  = (dst & ~m) | r;
        fl.n = top_bit(r, sz);
        fl.z = (r == '0);
        fl.v = 1'b0;
        if (cnt == '0) begin
          fl.c = 1'b0;
        end else if (op == m68k_pkg::OP_ROL) begin
          fl.c = r[0];
        end else begin
          fl.c = top_bit(r, sz);
        end
      end
      m68k_pkg::OP_BTST, m68k_pkg::OP_BCHG, m68k_pkg::OP_BCLR, m68k_pkg::OP_BSET: begin
        fl.z = ((dst & bitm) == '0);
        if (op == m68k_pkg::OP_BCHG) begin
          res = dst ^ bitm;
        end else if (op == m68k_pkg::OP_BCLR) begin
          res = dst & ~bitm;
        end else if (op == m68k_pkg::OP_BSET) begin
          res = dst | bitm;
        end
      end
      m68k_pkg::OP_COND: begin
        case (cc)
          m68k_pkg::CC_T:  ct = 1'b1;
          m68k_pkg::CC_F:  ct = 1'b0;
          m68k_pkg::CC_HI: ct = !flags.c && !flags.z;
          m68k_pkg::CC_LS: ct = flags.c || flags.z;
          m68k_pkg::CC_CC: ct = !flags.c;
          m68k_pkg::CC_CS: ct = flags.c;
          m68k_pkg::CC_NE: ct = !flags.z;
          m68k_pkg::CC_EQ: ct = flags.z;
          m68k_pkg::CC_VC: ct = !flags.v;
          m68k_pkg::CC_VS: ct = flags.v;
          m68k_pkg::CC_PL: ct = !flags.n;
          m68k_pkg::CC_MI: ct = flags.n;
          m68k_pkg::CC_GE: ct = (flags.n == flags.v);
          m68k_pkg::CC_LT: ct = (flags.n != flags.v);
          m68k_pkg::CC_GT: ct = !flags.z && (flags.n == flags.v);
          default:         ct = flags.z || (flags.n != flags.v);
        endcase
      end
      default: begin
        res = dst;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      flags     <= fl;
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.result_value <= res;
      result.flag_n       <= fl.n;
      result.flag_z       <= fl.z;
      result.flag_v       <= fl.v;
      result.flag_c       <= fl.c;
      result.cond_true    <= ct;
    end
  end

  assign result.valid = out_valid;

endmodule

>>> src/m68k_alu_and_condition_test_core.sv
// path from request accept to result valid: front register, queue, result
// register; throughput: one item per cycle while result.ready is high, set by the
// combinational alu in the back stage and the two-entry queue
// reset: synchronous; clears front, queue and result valids and the nzvc flags
// top level of the m68k alu core; depends on m68k_pkg, m68k_if, m68k_front,
// m68k_queue, m68k_back and the assertion macro header
`timescale 1ns / 1ps

`include "m68k_alu_and_condition_test_core_assert.svh"

module m68k_alu_and_condition_test_core #(
  parameter int QUEUE_DEPTH = m68k_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  m68k_req_if.sink     request,
  m68k_rsp_if.source   result
);

  m68k_pkg::entry_t   front;
  m68k_pkg::entry_t   head;
  m68k_pkg::q_stat_t  q_stat;
  logic               pop;
  logic               logic_op_pop;
  logic               keep_pop;
  logic               other_pop;
  logic [31:0]        head_dest;

  m68k_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .q_stat  (q_stat),
    .front   (front)
  );

  m68k_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .front (front),
    .pop   (pop),
    .head  (head),
    .stat  (q_stat)
  );

  m68k_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

  assign logic_op_pop = pop && (head.item.op == m68k_pkg::OP_AND ||
                                head.item.op == m68k_pkg::OP_OR ||
                                head.item.op == m68k_pkg::OP_EOR);
  assign keep_pop     = pop && (head.item.op == m68k_pkg::OP_COND ||
                                head.item.op == m68k_pkg::OP_NOP);
  assign other_pop    = pop && head.item.op != m68k_pkg::OP_COND;
  assign head_dest    = head.item.dest_value;

  `M68K_ASSERT_NXT(a_accept_loads_front, clk, rst, request.valid && request.ready, front.valid)
  `M68K_ASSERT_NXT(a_logic_clears_vc, clk, rst, logic_op_pop, !result.flag_v && !result.flag_c)
  `M68K_ASSERT_NXT(a_cond_keeps_dest, clk, rst, keep_pop, result.result_value == $past(head_dest))
  `M68K_ASSERT_NXT(a_cond_true_only_test, clk, rst, other_pop, !result.cond_true)

endmodule
